// ----- rtl/srn_pkg.sv -----
// package for the rotated sprite sampler
// request and result structs, size defaults and the quarter-wave sine table
package srn_pkg;

  localparam int DEF_MAX_SOURCE_WIDTH  = 256;
  localparam int DEF_MAX_SOURCE_HEIGHT = 256;
  localparam int DEF_FRACTION_BITS     = 14;
  localparam int TABLE_BITS            = 14;
  localparam int DEST_LIMIT            = 512;

  localparam logic [31:0] KEY_COLOUR = 32'h00ff00ff;

  localparam logic [1:0] REG_SOURCE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SOURCE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_ROTATION      = 2'd2;
  localparam logic [1:0] REG_SAMPLE_STEP   = 2'd3;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  typedef struct packed {
    logic        func;
    logic [8:0]  coord_x;
    logic [8:0]  coord_y;
    logic [31:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [31:0] pixel_out;
    logic        covered;
    logic        out_of_frame;
    logic [9:0]  frame_width;
    logic [9:0]  frame_height;
  } out_item_t;

  // round(sin(k deg) * 2^14), k = 0..90
  localparam logic [14:0] QSINE [0:90] = '{
    15'd0, 15'd286, 15'd572, 15'd857, 15'd1143, 15'd1428, 15'd1713, 15'd1997,
    15'd2280, 15'd2563, 15'd2845, 15'd3126, 15'd3406, 15'd3686, 15'd3964,
    15'd4240, 15'd4516, 15'd4790, 15'd5063, 15'd5334, 15'd5604, 15'd5872,
    15'd6138, 15'd6402, 15'd6664, 15'd6924, 15'd7182, 15'd7438, 15'd7692,
    15'd7943, 15'd8192, 15'd8438, 15'd8682, 15'd8923, 15'd9162, 15'd9397,
    15'd9630, 15'd9860, 15'd10087, 15'd10311, 15'd10531, 15'd10749, 15'd10963,
    15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176, 15'd12365,
    15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421, 15'd13583,
    15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466, 15'd14598,
    15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296, 15'd15396,
    15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897, 15'd15964,
    15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262, 15'd16294,
    15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
  };

endpackage

// ----- rtl/sprite_rotation_nearest_top.sv -----
// rotated sprite sampler top level: sequencer, shared multiplier, source store
// depends on srn_pkg and srn_ram
//
// Write requests (func 0) store one source pixel each.
// Read requests (func 1) return the rotated image's pixel at a destination
// coordinate, or the key colour 0xff00ff, along with the destination size.
// A sampled read sends the eight products of the geometry and of the inverse
// mapping one per cycle through a single signed multiplier, takes the step
// remainders one bit per cycle, and takes the pixel from the store's
// registered read port. A read that is out of frame or off the sampling
// grid skips the mapping. The block takes no request while a read is at
// work, nor while a finished read waits behind an untaken result, so at the
// earliest the next request is accepted in the same cycle in which the
// result is first presented. The source store has no reset; only pixels
// that were written may be read.
module sprite_rotation_nearest_top
  import srn_pkg::*;
#(
  parameter int MAX_SOURCE_WIDTH  = DEF_MAX_SOURCE_WIDTH,
  parameter int MAX_SOURCE_HEIGHT = DEF_MAX_SOURCE_HEIGHT,
  parameter int FRACTION_BITS     = DEF_FRACTION_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_data
);

  localparam int FB    = FRACTION_BITS;
  localparam int DEPTH = MAX_SOURCE_WIDTH * MAX_SOURCE_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int TW    = FB + 2;          // signed sin/cos
  localparam int BW    = FB + 14;         // corners and box limits
  localparam int XW    = BW + 1;          // shifted destination coordinate
  localparam int PW    = XW + TW;         // product
  localparam int SW    = PW + 1;          // mapped coordinate
  localparam int IW    = SW - 2 * FB;     // integer part of mapped coordinate
  localparam int UP    = (FB >= TABLE_BITS) ? FB - TABLE_BITS : 0;
  localparam int DOWN  = (TABLE_BITS > FB) ? TABLE_BITS - FB : 0;
  localparam int RND   = (DOWN > 0) ? DOWN - 1 : 0;
  localparam int TT    = 16 + UP;

  typedef enum logic [3:0] {
    S_IDLE, S_TRIG, S_GEO, S_BOX1, S_BOX2, S_BOX3, S_MOD, S_CHK, S_SAMP, S_ADDR, S_FIN
  } state_t;

  function automatic logic signed [TW-1:0] trig(input logic [6:0] k);
    logic [TT-1:0] t;
    t = TT'(QSINE[k]) << UP;
    if (DOWN != 0) begin
      t = (t + (TT'(1) << RND)) >> DOWN;
    end
    return TW'(t);
  endfunction

  state_t state_r;
  logic [8:0] src_w_r, src_h_r, rot_r;
  logic [4:0] step_r;
  logic [8:0] x_r, y_r;
  logic signed [TW-1:0] s_r, c_r;
  logic [2:0] cnt_r;
  logic [3:0] bit_r;
  logic signed [PW-1:0] prod_r;
  logic signed [BW-1:0] p_r [0:3];
  logic signed [BW-1:0] p1x_r, p2x_r, p2y_r;
  logic signed [BW-1:0] minx_r, miny_r, maxx_r, maxy_r;
  logic [9:0] out_w_r, out_h_r;
  logic signed [XW-1:0] bx_r, by_r;
  logic [5:0] remx_r, remy_r;
  logic signed [SW-1:0] sx_r, sy_r;
  logic cover_r, off_r;
  logic out_valid_r;
  out_item_t out_r;

  logic [31:0] rdata;
  logic [AW-1:0] raddr;
  logic [8:0] ang;
  logic signed [TW-1:0] s_nxt, c_nxt;
  logic signed [XW-1:0] mul_a;
  logic signed [TW-1:0] mul_b;
  logic signed [PW-1:0] mul_p;
  logic [1:0] pidx;
  logic signed [BW-1:0] mnx, mny, mxx, mxy, m01;
  logic [BW-1:0] magx, magy, negx, negy;
  logic [BW:0] totx, toty;
  logic [5:0] step_eff, rx_sh, ry_sh;
  logic wr_en;
  logic [AW-1:0] waddr;
  logic [IW-1:0] ix, iy;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign wr_en = in_valid && in_ready && (in_data.func == FUNC_WRITE) &&
                 (32'(in_data.coord_x) < 32'(MAX_SOURCE_WIDTH)) &&
                 (32'(in_data.coord_y) < 32'(MAX_SOURCE_HEIGHT));
  assign waddr = AW'(32'(in_data.coord_y) * MAX_SOURCE_WIDTH + 32'(in_data.coord_x));

  srn_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (waddr),
    .wdata (in_data.pixel_in),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign ang = (rot_r >= 9'd360) ? rot_r - 9'd360 : rot_r;

  always_comb begin
    if (ang <= 9'd90) begin
      s_nxt = trig(ang[6:0]);
      c_nxt = trig(7'(9'd90 - ang));
    end else if (ang <= 9'd180) begin
      s_nxt = trig(7'(9'd180 - ang));
      c_nxt = -trig(7'(ang - 9'd90));
    end else if (ang <= 9'd270) begin
      s_nxt = -trig(7'(ang - 9'd180));
      c_nxt = -trig(7'(9'd270 - ang));
    end else begin
      s_nxt = -trig(7'(9'd360 - ang));
      c_nxt = trig(7'(ang - 9'd270));
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = s_r;
    if (state_r == S_GEO) begin
      unique case (cnt_r[1:0])
        2'd0: begin mul_a = XW'($signed({1'b0, src_h_r})); mul_b = s_r; end
        2'd1: begin mul_a = XW'($signed({1'b0, src_h_r})); mul_b = c_r; end
        2'd2: begin mul_a = XW'($signed({1'b0, src_w_r})); mul_b = c_r; end
        default: begin mul_a = XW'($signed({1'b0, src_w_r})); mul_b = s_r; end
      endcase
    end else begin
      unique case (cnt_r[1:0])
        2'd0: begin mul_a = bx_r; mul_b = c_r; end
        2'd1: begin mul_a = by_r; mul_b = s_r; end
        2'd2: begin mul_a = by_r; mul_b = c_r; end
        default: begin mul_a = bx_r; mul_b = s_r; end
      endcase
    end
  end
  assign mul_p = PW'(mul_a) * PW'(mul_b);
  assign pidx  = 2'(cnt_r - 3'd1);

  // box limits
  always_comb begin
    m01 = (p1x_r < 0) ? p1x_r : '0;
    mnx = (p2x_r < p_r[2]) ? p2x_r : p_r[2];
    mnx = (m01 < mnx) ? m01 : mnx;
    mxx = (p1x_r > p2x_r) ? p1x_r : p2x_r;
    mxx = (mxx > p_r[2]) ? mxx : p_r[2];
    if (ang > 9'd90 && ang < 9'd180) begin
      mxx = '0;
    end
    mny = (p_r[1] < 0) ? p_r[1] : '0;
    mny = (mny < p2y_r) ? mny : p2y_r;
    mny = (mny < p_r[3]) ? mny : p_r[3];
    mxy = (p_r[1] > p2y_r) ? p_r[1] : p2y_r;
    mxy = (mxy > p_r[3]) ? mxy : p_r[3];
    if (ang > 9'd180 && ang < 9'd270) begin
      mxy = '0;
    end
  end

  // destination edges: truncated max plus rounded-up min
  always_comb begin
    magx = BW'(maxx_r < 0 ? -maxx_r : maxx_r);
    magy = BW'(maxy_r < 0 ? -maxy_r : maxy_r);
    negx = BW'(-minx_r);
    negy = BW'(-miny_r);
    totx = (BW + 1)'(magx >> FB) +
           (BW + 1)'(((BW + 1)'(negx) + (BW + 1)'((1 << FB) - 1)) >> FB);
    toty = (BW + 1)'(magy >> FB) +
           (BW + 1)'(((BW + 1)'(negy) + (BW + 1)'((1 << FB) - 1)) >> FB);
  end

  assign step_eff = (step_r == 5'd0) ? 6'd1 : {1'b0, step_r};
  assign rx_sh    = {remx_r[4:0], x_r[bit_r]};
  assign ry_sh    = {remy_r[4:0], y_r[bit_r]};
  assign ix       = IW'(sx_r >>> (2 * FB));
  assign iy       = IW'(sy_r >>> (2 * FB));
  // address follows the mapped coordinate so the pixel is ready by S_FIN
  assign raddr    = AW'(32'(iy) * MAX_SOURCE_WIDTH + 32'(ix));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      src_w_r     <= 9'd1;
      src_h_r     <= 9'd1;
      rot_r       <= 9'd0;
      step_r      <= 5'd1;
      minx_r      <= '0;
      miny_r      <= '0;
      out_w_r     <= '0;
      out_h_r     <= '0;
      cnt_r       <= '0;
      bit_r       <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SOURCE_WIDTH:  src_w_r <= cfg_data;
          REG_SOURCE_HEIGHT: src_h_r <= cfg_data;
          REG_ROTATION:      rot_r   <= cfg_data;
          default:           step_r  <= cfg_data[4:0];
        endcase
      end
      if (out_valid_r && out_ready && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid && in_data.func == FUNC_READ) begin
            x_r     <= in_data.coord_x;
            y_r     <= in_data.coord_y;
            state_r <= S_TRIG;
          end
        end
        S_TRIG: begin
          s_r     <= s_nxt;
          c_r     <= c_nxt;
          cnt_r   <= '0;
          state_r <= S_GEO;
        end
        S_GEO: begin
          prod_r <= mul_p;
          if (cnt_r != 3'd0) begin
            p_r[pidx] <= BW'(prod_r);
          end
          cnt_r <= cnt_r + 3'd1;
          if (cnt_r == 3'd4) begin
            state_r <= S_BOX1;
          end
        end
        S_BOX1: begin
          // p_r: h*s, h*c, w*c, w*s
          p1x_r   <= -p_r[0];
          p2x_r   <= p_r[2] - p_r[0];
          p2y_r   <= p_r[1] + p_r[3];
          state_r <= S_BOX2;
        end
        S_BOX2: begin
          minx_r  <= mnx;
          miny_r  <= mny;
          maxx_r  <= mxx;
          maxy_r  <= mxy;
          state_r <= S_BOX3;
        end
        S_BOX3: begin
          out_w_r <= (totx > (BW + 1)'(DEST_LIMIT)) ? 10'(DEST_LIMIT) : 10'(totx);
          out_h_r <= (toty > (BW + 1)'(DEST_LIMIT)) ? 10'(DEST_LIMIT) : 10'(toty);
          bx_r    <= XW'($signed({1'b0, x_r, FB'(0)})) + XW'(minx_r);
          by_r    <= XW'($signed({1'b0, y_r, FB'(0)})) + XW'(miny_r);
          remx_r  <= '0;
          remy_r  <= '0;
          bit_r   <= 4'd8;
          state_r <= S_MOD;
        end
        S_MOD: begin
          // restoring remainder, one bit of x and y a cycle
          remx_r <= (rx_sh >= step_eff) ? rx_sh - step_eff : rx_sh;
          remy_r <= (ry_sh >= step_eff) ? ry_sh - step_eff : ry_sh;
          bit_r  <= bit_r - 4'd1;
          if (bit_r == 4'd0) begin
            state_r <= S_CHK;
          end
        end
        S_CHK: begin
          off_r   <= ({1'b0, x_r} >= out_w_r) || ({1'b0, y_r} >= out_h_r);
          cover_r <= 1'b0;
          cnt_r   <= '0;
          if (({1'b0, x_r} >= out_w_r) || ({1'b0, y_r} >= out_h_r) ||
              remx_r != 6'd0 || remy_r != 6'd0) begin
            state_r <= S_FIN;
          end else begin
            state_r <= S_SAMP;
          end
        end
        S_SAMP: begin
          prod_r <= mul_p;
          unique case (cnt_r)
            3'd1: sx_r <= SW'(prod_r);
            3'd2: sx_r <= sx_r + SW'(prod_r);
            3'd3: sy_r <= SW'(prod_r);
            3'd4: sy_r <= sy_r - SW'(prod_r);
            default: ;
          endcase
          cnt_r <= cnt_r + 3'd1;
          if (cnt_r == 3'd4) begin
            state_r <= S_ADDR;
          end
        end
        S_ADDR: begin
          cover_r <= (sx_r >= 0) && (sy_r >= 0) &&
                     (ix < IW'(src_w_r)) && (iy < IW'(src_h_r)) &&
                     (32'(ix) < 32'(MAX_SOURCE_WIDTH)) &&
                     (32'(iy) < 32'(MAX_SOURCE_HEIGHT));
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid_r || out_ready) begin
            out_r.pixel_out    <= cover_r ? rdata : KEY_COLOUR;
            out_r.covered      <= cover_r;
            out_r.out_of_frame <= off_r;
            out_r.frame_width  <= out_w_r;
            out_r.frame_height <= out_h_r;
            out_valid_r        <= 1'b1;
            state_r            <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/srn_ram.sv -----
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module srn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
